// ===== design/lgc_pkg.sv =====
`timescale 1ns / 1ps
package lgc_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned DIFF_W  = 17;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned N_CHAN  = 3;

  localparam logic [1:0] MODE_ZERO = 2'd0;
  localparam logic [1:0] MODE_ONE  = 2'd1;
  localparam logic [1:0] MODE_DIV  = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [COLOR_W-1:0] start_color;
    logic [COLOR_W-1:0] end_color;
  } lgc_ctl_t;

endpackage

// ===== design/lgc_intf.sv =====
`timescale 1ns / 1ps
interface lgc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cur_x;
  logic signed [15:0] cur_y;
  logic [23:0]        cur_color;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic [23:0]        start_color;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;
  logic [23:0]        end_color;
  logic signed [16:0] extent_x;
  logic signed [16:0] extent_y;

  modport source (
    output valid, cur_x, cur_y, cur_color, start_x, start_y, start_color,
           end_x, end_y, end_color, extent_x, extent_y,
    input  ready
  );
  modport sink (
    input  valid, cur_x, cur_y, cur_color, start_x, start_y, start_color,
           end_x, end_y, end_color, extent_x, extent_y,
    output ready
  );
endinterface

interface lgc_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_color;

  modport source (output valid, pixel_color, input ready);
  modport sink (input valid, pixel_color, output ready);
endinterface

// ===== design/lgc_front.sv =====
`timescale 1ns / 1ps
module lgc_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  lgc_in_if.sink                                in_chan,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output lgc_pkg::lgc_ctl_t                     ctl_o,
  output logic [lgc_pkg::DIFF_W-1:0]            rem_o,
  output logic [lgc_pkg::COORD_W-1:0]           ad_o
);

  logic                                 a_valid_r;
  logic                                 b_valid_r;
  logic                                 a_en;
  logic                                 b_en;

  logic                                 use_x;
  logic signed [lgc_pkg::COORD_W-1:0]   cur_sel;
  logic signed [lgc_pkg::COORD_W-1:0]   st_sel;
  logic signed [lgc_pkg::COORD_W-1:0]   en_sel;
  logic [lgc_pkg::DIFF_W-1:0]           place_nxt;
  logic [lgc_pkg::DIFF_W-1:0]           dist_nxt;
  logic [lgc_pkg::DIFF_W-1:0]           place_r;
  logic [lgc_pkg::DIFF_W-1:0]           dist_r;
  logic                                 bypass_r;
  logic [lgc_pkg::COLOR_W-1:0]          a_start_r;
  logic [lgc_pkg::COLOR_W-1:0]          a_end_r;

  logic [lgc_pkg::DIFF_W-1:0]           ap;
  logic [lgc_pkg::DIFF_W-1:0]           ad;
  logic [1:0]                           mode_nxt;
  lgc_pkg::lgc_ctl_t                    ctl_r;
  logic [lgc_pkg::DIFF_W-1:0]           rem_r;
  logic [lgc_pkg::COORD_W-1:0]          ad_r;

  assign b_en          = !b_valid_r || ready_i;
  assign a_en          = !a_valid_r || b_en;
  assign in_chan.ready = a_en;

  // axis select and differences
  always_comb begin
    use_x     = in_chan.extent_x > in_chan.extent_y;
    cur_sel   = use_x ? in_chan.cur_x   : in_chan.cur_y;
    st_sel    = use_x ? in_chan.start_x : in_chan.start_y;
    en_sel    = use_x ? in_chan.end_x   : in_chan.end_y;
    place_nxt = {cur_sel[lgc_pkg::COORD_W-1], cur_sel} - {st_sel[lgc_pkg::COORD_W-1], st_sel};
    dist_nxt  = {en_sel[lgc_pkg::COORD_W-1], en_sel} - {st_sel[lgc_pkg::COORD_W-1], st_sel};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_en) begin
      a_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      place_r   <= place_nxt;
      dist_r    <= dist_nxt;
      bypass_r  <= in_chan.cur_color == in_chan.end_color;
      a_start_r <= in_chan.start_color;
      a_end_r   <= in_chan.end_color;
    end
  end

  // magnitudes and fraction class
  always_comb begin
    ap = place_r[lgc_pkg::DIFF_W-1] ? (lgc_pkg::DIFF_W'(0) - place_r) : place_r;
    ad = dist_r[lgc_pkg::DIFF_W-1]  ? (lgc_pkg::DIFF_W'(0) - dist_r)  : dist_r;
    if (bypass_r || dist_r == '0) begin
      mode_nxt = lgc_pkg::MODE_ONE;
    end else if (place_r == '0 ||
                 place_r[lgc_pkg::DIFF_W-1] != dist_r[lgc_pkg::DIFF_W-1]) begin
      mode_nxt = lgc_pkg::MODE_ZERO;
    end else if (ap >= ad) begin
      mode_nxt = lgc_pkg::MODE_ONE;
    end else begin
      mode_nxt = lgc_pkg::MODE_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      ctl_r.mode        <= mode_nxt;
      ctl_r.start_color <= a_start_r;
      ctl_r.end_color   <= a_end_r;
      rem_r             <= ap;
      ad_r              <= ad[lgc_pkg::COORD_W-1:0];
    end
  end

  assign valid_o = b_valid_r;
  assign ctl_o   = ctl_r;
  assign rem_o   = rem_r;
  assign ad_o    = ad_r;

endmodule

// ===== design/lgc_div_stage.sv =====
`timescale 1ns / 1ps
module lgc_div_stage #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  lgc_pkg::lgc_ctl_t           ctl_i,
  input  logic [lgc_pkg::DIFF_W-1:0]  rem_i,
  input  logic [lgc_pkg::COORD_W-1:0] ad_i,
  input  logic [FRAC_BITS-1:0]        q_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output lgc_pkg::lgc_ctl_t           ctl_o,
  output logic [lgc_pkg::DIFF_W-1:0]  rem_o,
  output logic [lgc_pkg::COORD_W-1:0] ad_o,
  output logic [FRAC_BITS-1:0]        q_o
);

  logic                         valid_r;
  logic                         en;
  logic [lgc_pkg::DIFF_W-1:0]   shifted;
  logic                         bit_nxt;
  logic [lgc_pkg::DIFF_W-1:0]   rem_nxt;
  lgc_pkg::lgc_ctl_t            ctl_r;
  logic [lgc_pkg::DIFF_W-1:0]   rem_r;
  logic [lgc_pkg::COORD_W-1:0]  ad_r;
  logic [FRAC_BITS-1:0]         q_r;

  assign en      = !valid_r || ready_i;
  assign ready_o = en;

  // one restoring quotient bit
  always_comb begin
    shifted = {rem_i[lgc_pkg::DIFF_W-2:0], 1'b0};
    bit_nxt = shifted >= {1'b0, ad_i};
    rem_nxt = bit_nxt ? (shifted - {1'b0, ad_i}) : shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r <= ctl_i;
      rem_r <= rem_nxt;
      ad_r  <= ad_i;
      q_r   <= {q_i[FRAC_BITS-2:0], bit_nxt};
    end
  end

  assign valid_o = valid_r;
  assign ctl_o   = ctl_r;
  assign rem_o   = rem_r;
  assign ad_o    = ad_r;
  assign q_o     = q_r;

endmodule

// ===== design/lgc_blend.sv =====
`timescale 1ns / 1ps
module lgc_blend #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  lgc_pkg::lgc_ctl_t    ctl_i,
  input  logic [FRAC_BITS-1:0] q_i,
  lgc_out_if.source            out_chan
);

  localparam int unsigned P_W    = FRAC_BITS + 1;
  localparam int unsigned PROD_W = FRAC_BITS + 11;

  logic                               m_valid_r;
  logic                               o_valid_r;
  logic                               m_en;
  logic                               o_en;
  logic [P_W-1:0]                     p;
  logic [lgc_pkg::CHAN_W:0]           d [lgc_pkg::N_CHAN];
  logic signed [PROD_W-1:0]           prod_nxt [lgc_pkg::N_CHAN];
  logic signed [PROD_W-1:0]           prod_r [lgc_pkg::N_CHAN];
  logic [lgc_pkg::COLOR_W-1:0]        start_r;
  logic [lgc_pkg::COLOR_W-1:0]        pixel_nxt;
  logic [lgc_pkg::COLOR_W-1:0]        pixel_r;

  assign o_en    = !o_valid_r || out_chan.ready;
  assign m_en    = !m_valid_r || o_en;
  assign ready_o = m_en;

  // start + p * (end - start), per channel
  always_comb begin
    if (ctl_i.mode == lgc_pkg::MODE_DIV) begin
      p = {1'b0, q_i};
    end else if (ctl_i.mode == lgc_pkg::MODE_ONE) begin
      p = {1'b1, {FRAC_BITS{1'b0}}};
    end else begin
      p = '0;
    end
    for (int c = 0; c < lgc_pkg::N_CHAN; c++) begin
      d[c] = {1'b0, ctl_i.end_color[c*lgc_pkg::CHAN_W +: lgc_pkg::CHAN_W]}
           - {1'b0, ctl_i.start_color[c*lgc_pkg::CHAN_W +: lgc_pkg::CHAN_W]};
      prod_nxt[c] = $signed({{(PROD_W-lgc_pkg::CHAN_W-1){d[c][lgc_pkg::CHAN_W]}}, d[c]})
                  * $signed({{(PROD_W-P_W){1'b0}}, p});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (m_en) begin
      m_valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (m_en) begin
      prod_r  <= prod_nxt;
      start_r <= ctl_i.start_color;
    end
  end

  always_comb begin
    for (int c = 0; c < lgc_pkg::N_CHAN; c++) begin
      pixel_nxt[c*lgc_pkg::CHAN_W +: lgc_pkg::CHAN_W] =
        prod_r[c][FRAC_BITS +: lgc_pkg::CHAN_W] + start_r[c*lgc_pkg::CHAN_W +: lgc_pkg::CHAN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (o_en) begin
      o_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_en) begin
      pixel_r <= pixel_nxt;
    end
  end

  assign out_chan.valid       = o_valid_r;
  assign out_chan.pixel_color = pixel_r;

endmodule

// ===== design/line_gradient_color_top.sv =====
`timescale 1ns / 1ps
// channel    | dir | payload
// in_chan    | in  | cur/start/end x, y and color, extent_x, extent_y
// out_chan   | out | pixel_color
//
// one transaction per clock sustained while out_chan.ready holds high; pipeline stages:
// two front stages, one divider stage per quotient bit, two blend stages
// rst_n synchronous, clears the stage valid bits only
// each stage holds while the next is full and stalled; bubbles are squeezed out
module line_gradient_color_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  lgc_in_if.sink    in_chan,
  lgc_out_if.source out_chan
);

  logic                        v   [FRAC_BITS+1];
  logic                        rdy [FRAC_BITS+1];
  lgc_pkg::lgc_ctl_t           ctl [FRAC_BITS+1];
  logic [lgc_pkg::DIFF_W-1:0]  rem [FRAC_BITS+1];
  logic [lgc_pkg::COORD_W-1:0] ad  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0]        q   [FRAC_BITS+1];

  lgc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .valid_o (v[0]),
    .ready_i (rdy[0]),
    .ctl_o   (ctl[0]),
    .rem_o   (rem[0]),
    .ad_o    (ad[0])
  );

  assign q[0] = '0;

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    lgc_div_stage #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (v[i]),
      .ready_o (rdy[i]),
      .ctl_i   (ctl[i]),
      .rem_i   (rem[i]),
      .ad_i    (ad[i]),
      .q_i     (q[i]),
      .valid_o (v[i+1]),
      .ready_i (rdy[i+1]),
      .ctl_o   (ctl[i+1]),
      .rem_o   (rem[i+1]),
      .ad_o    (ad[i+1]),
      .q_o     (q[i+1])
    );
  end

  lgc_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (v[FRAC_BITS]),
    .ready_o  (rdy[FRAC_BITS]),
    .ctl_i    (ctl[FRAC_BITS]),
    .q_i      (q[FRAC_BITS]),
    .out_chan (out_chan)
  );

endmodule
